/* sv/tbc_pkg.sv */
`default_nettype none
package tbc_pkg;

  localparam int MAX_BUTTONS   = 16;
  localparam int SLOT_W        = $clog2(MAX_BUTTONS);
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int DIV_NUM_W     = 26;
  localparam int DIV_DEN_W     = 10;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_RESISTANCE = 3'd1;
  localparam logic [2:0] REG_X_MIN      = 3'd2;
  localparam logic [2:0] REG_X_MAX      = 3'd3;
  localparam logic [2:0] REG_Y_MIN      = 3'd4;
  localparam logic [2:0] REG_Y_MAX      = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd6;

  typedef struct packed {
    cmd_t        command;
    logic [9:0]  raw_x;
    logic [9:0]  raw_y;
    logic [9:0]  z_first;
    logic [9:0]  z_second;
    logic [31:0] time_ms;
    logic [9:0]  rect_left;
    logic [9:0]  rect_top;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [7:0]  button_id;
  } item_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] resistance;
    logic [9:0]  x_min;
    logic [9:0]  x_max;
    logic [9:0]  y_min;
    logic [9:0]  y_max;
    logic [15:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic        touched;
    logic [9:0]  touch_x;
    logic [9:0]  touch_y;
    logic [15:0] pressure;
    logic [7:0]  down_id;
    logic [7:0]  released_id;
    logic        add_dropped;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_PRE, ST_DIVP, ST_DIVX, ST_DIVY,
    ST_UPD, ST_HIT, ST_ADD, ST_REM, ST_TRIM, ST_DONE
  } back_st_t;

endpackage
`default_nettype wire

/* sv/touch_button_controller_top.sv */
`default_nettype none
// channel  | direction | handshake          | payload
// in_      | input     | in_tvalid/tready   | tdata raw coords, z, time, rect, id; tuser command
// out_     | output    | out_tvalid/tready  | tdata touched, x, y, pressure, ids, dropped
// cfg_     | input     | cfg_we             | cfg_addr register index, cfg_wdata value
//
// a sample request makes three passes through the shared serial divider in the back end
// (pressure, screen x, screen y) and, while no button is held and the debounced state is
// touched, a hit test over the button table; requests pass the input register and queue first
// add, remove by id (one slot per cycle over the whole table) and clear edit the table
// reset is synchronous, active low; the button table comes up empty
// the input register and a two-deep queue keep accepting while the back end works;
// a finished result waits in the output register and only the next finish stalls on it
module touch_button_controller_top
  import tbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // raw_x, raw_y, z_first, z_second, time_ms, rect_left, rect_top,
  // rect_width, rect_height, button_id
  input  wire logic [119:0] in_tdata,
  // command
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // touched, touch_x, touch_y, pressure, down_id, released_id, add_dropped, 2 pad bits
  output logic [55:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);

  cfg_t  cfg_r;
  item_t f_item, q_item;
  logic  f_push, q_full, q_pop, q_valid;
  res_t  res;

  // configuration registers, write only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= 16'd10;
      cfg_r.resistance <= 16'd300;
      cfg_r.x_min      <= 10'd150;
      cfg_r.x_max      <= 10'd920;
      cfg_r.y_min      <= 10'd120;
      cfg_r.y_max      <= 10'd940;
      cfg_r.debounce   <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_THRESHOLD:  cfg_r.threshold  <= cfg_wdata;
        REG_RESISTANCE: cfg_r.resistance <= cfg_wdata;
        REG_X_MIN:      cfg_r.x_min      <= cfg_wdata[9:0];
        REG_X_MAX:      cfg_r.x_max      <= cfg_wdata[9:0];
        REG_Y_MIN:      cfg_r.y_min      <= cfg_wdata[9:0];
        REG_Y_MAX:      cfg_r.y_max      <= cfg_wdata[9:0];
        REG_DEBOUNCE:   cfg_r.debounce   <= cfg_wdata;
        default: ;  // unused index
      endcase
    end
  end

  // front end: input register and decode
  tbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (f_push),
    .q_item    (f_item),
    .q_full    (q_full)
  );

  // short queue between front and back
  tbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  // back end: pressure, scaling, debounce, hit test and table edits
  tbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.add_dropped, res.released_id, res.down_id,
                      res.pressure, res.touch_y, res.touch_x, res.touched};

endmodule
`default_nettype wire

/* sv/tbc_div.sv */
`default_nettype none
module tbc_div
  import tbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

/* sv/tbc_fifo.sv */
`default_nettype none
module tbc_fifo
  import tbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      pop_item
);

  item_t      mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_item  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule
`default_nettype wire

/* sv/tbc_front.sv */
`default_nettype none
module tbc_front
  import tbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [119:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  output logic              q_push,
  output item_t             q_item,
  input  wire logic         q_full
);

  logic  vld_r;
  item_t item_r;
  item_t dec;

  // unpack the request; fields of other kinds are kept but unused by the back end
  always_comb begin
    dec.command     = cmd_t'(in_tuser);
    dec.raw_x       = in_tdata[9:0];
    dec.raw_y       = in_tdata[19:10];
    dec.z_first     = in_tdata[29:20];
    dec.z_second    = in_tdata[39:30];
    dec.time_ms     = in_tdata[71:40];
    dec.rect_left   = in_tdata[81:72];
    dec.rect_top    = in_tdata[91:82];
    dec.rect_width  = in_tdata[101:92];
    dec.rect_height = in_tdata[111:102];
    dec.button_id   = in_tdata[119:112];
  end

  assign q_push    = vld_r && !q_full;
  assign q_item    = item_r;
  assign in_tready = !vld_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= dec;
  end

endmodule
`default_nettype wire

/* sv/tbc_back.sv */
`default_nettype none
module tbc_back
  import tbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res
);

  localparam logic [9:0] X_TOP = 10'(SCREEN_WIDTH - 1);
  localparam logic [9:0] Y_TOP = 10'(SCREEN_HEIGHT - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_BUTTONS - 1);

  typedef struct packed {
    logic [9:0] left;
    logic [9:0] top;
    logic [9:0] width;
    logic [9:0] height;
    logic [7:0] id;
  } slot_t;

  function automatic logic [9:0] scale_fin(input logic [20:0] q, input logic neg,
                                           input logic dz, input logic [9:0] top);
    logic signed [22:0] qs;
    logic signed [22:0] r;
    qs = dz ? 23'sd0 : (neg ? -$signed({2'b0, q}) : $signed({2'b0, q}));
    r  = $signed({13'b0, top}) - qs;
    if (r < 0) return 10'd0;
    else if (r > $signed({13'b0, top})) return top;
    else return r[9:0];
  endfunction

  back_st_t st_r, st_nxt;
  item_t    cur_r;

  // debounce and hold state
  logic        deb_r;
  logic [31:0] deadline_r;
  logic [9:0]  lx_r, ly_r;
  logic        held_r;
  logic [7:0]  held_id_r;

  // button table, packed from slot 0, newest first
  logic [MAX_BUTTONS-1:0] valid_r;
  slot_t                  slot_r [MAX_BUTTONS];
  logic [SLOT_W-1:0]      idx_r;
  logic [SLOT_W:0]        wr_r;
  slot_t                  rd_slot;

  // per-item datapath
  logic [19:0]        prod1_r;
  logic signed [20:0] sxn_r, syn_r;
  logic signed [10:0] dx_r, dy_r;
  logic [15:0]        p_r;
  logic [9:0]         sx_r;
  logic [7:0]         down_r, rel_r;
  logic               drop_r;
  logic               out_valid_r;
  res_t               out_r;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic [35:0]          prod_w;
  logic [20:0]          sxn_mag, syn_mag;
  logic [15:0]          praw;
  logic                 now_touch, flip, deb_n;
  logic                 hit;
  logic                 fin;

  tbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign prod_w  = 36'(prod1_r) * 36'(cfg.resistance);
  assign sxn_mag = sxn_r[20] ? 21'(-sxn_r) : 21'(sxn_r);
  assign syn_mag = syn_r[20] ? 21'(-syn_r) : 21'(syn_r);
  assign rd_slot = slot_r[idx_r];

  always_comb begin
    if (cfg.resistance == 16'd0)
      praw = 16'(11'd1023 + {1'b0, cur_r.z_first} - {1'b0, cur_r.z_second});
    else if (cur_r.z_first == 10'd0 || cur_r.z_second <= cur_r.z_first)
      praw = 16'd0;
    else if (div_quot > DIV_NUM_W'(16'hFFFF))
      praw = 16'hFFFF;
    else
      praw = div_quot[15:0];
  end

  assign now_touch = p_r != 16'd0;
  assign flip      = (cur_r.time_ms > deadline_r) && (deb_r != now_touch);
  assign deb_n     = flip ? now_touch : deb_r;
  assign hit       = valid_r[idx_r] && lx_r >= rd_slot.left &&
                     {1'b0, lx_r} < {1'b0, rd_slot.left} + {1'b0, rd_slot.width} &&
                     ly_r >= rd_slot.top &&
                     {1'b0, ly_r} < {1'b0, rd_slot.top} + {1'b0, rd_slot.height};
  assign fin       = !out_valid_r || out_ready;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.command)
            CMD_SAMPLE: st_nxt = ST_MUL;
            CMD_ADD:    st_nxt = ST_ADD;
            CMD_REMOVE: st_nxt = ST_REM;
            CMD_CLEAR:  st_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL:  st_nxt = ST_PRE;
      ST_PRE:  st_nxt = ST_DIVP;
      ST_DIVP: if (div_done) st_nxt = ST_DIVX;
      ST_DIVX: if (div_done) st_nxt = ST_DIVY;
      ST_DIVY: if (div_done) st_nxt = ST_UPD;
      ST_UPD: begin
        if (!held_r && deb_n) st_nxt = ST_HIT;
        else                  st_nxt = ST_DONE;
      end
      ST_HIT:  if (hit || idx_r == LAST_SLOT) st_nxt = ST_DONE;
      ST_ADD:  st_nxt = ST_DONE;
      ST_REM:  if (idx_r == LAST_SLOT) st_nxt = ST_TRIM;
      ST_TRIM: st_nxt = ST_DONE;
      ST_DONE: if (fin) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (st_r)
      ST_IDLE: q_pop = q_valid;
      ST_PRE: begin
        div_start = 1'b1;
        div_num   = prod_w[35:10];
        div_den   = cur_r.z_first;
      end
      ST_DIVP: begin
        div_start = div_done;
        div_num   = DIV_NUM_W'(sxn_mag);
        div_den   = dx_r[10] ? 10'(-dx_r) : dx_r[9:0];
      end
      ST_DIVX: begin
        div_start = div_done;
        div_num   = DIV_NUM_W'(syn_mag);
        div_den   = dy_r[10] ? 10'(-dy_r) : dy_r[9:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      deb_r       <= 1'b0;
      deadline_r  <= '0;
      lx_r        <= '0;
      ly_r        <= '0;
      held_r      <= 1'b0;
      held_id_r   <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && fin) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (q_valid && q_item.command == CMD_CLEAR) valid_r <= '0;
        ST_UPD: begin
          if (now_touch) begin
            lx_r <= sx_r;
            ly_r <= scale_fin(div_quot[20:0], syn_r[20] ^ dy_r[10], dy_r == 11'sd0, Y_TOP);
          end
          if (flip) begin
            deadline_r <= cur_r.time_ms + 32'(cfg.debounce);
            deb_r      <= now_touch;
          end
          if (held_r && !deb_n) held_r <= 1'b0;
        end
        ST_HIT: begin
          if (hit && rd_slot.id != 8'd0) begin
            held_r    <= 1'b1;
            held_id_r <= rd_slot.id;
          end
        end
        ST_ADD: begin
          if (!valid_r[MAX_BUTTONS-1]) valid_r <= {valid_r[MAX_BUTTONS-2:0], 1'b1};
        end
        ST_REM: begin
          if (valid_r[idx_r] && rd_slot.id != cur_r.button_id)
            valid_r[wr_r[SLOT_W-1:0]] <= 1'b1;
        end
        ST_TRIM: begin
          for (int k = 0; k < MAX_BUTTONS; k++)
            if ((SLOT_W+1)'(k) >= wr_r) valid_r[k] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload and table contents
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        cur_r  <= q_item;
        p_r    <= '0;
        down_r <= '0;
        rel_r  <= '0;
        drop_r <= 1'b0;
        idx_r  <= '0;
        wr_r   <= '0;
      end
      ST_MUL: begin
        prod1_r <= 20'(cur_r.z_second - cur_r.z_first) * 20'(cur_r.raw_x);
        dx_r    <= $signed({1'b0, cfg.x_max}) - $signed({1'b0, cfg.x_min});
        dy_r    <= $signed({1'b0, cfg.y_max}) - $signed({1'b0, cfg.y_min});
        sxn_r   <= 21'($signed({1'b0, cur_r.raw_x}) - $signed({1'b0, cfg.x_min}))
                   * $signed({11'b0, X_TOP});
        syn_r   <= 21'($signed({1'b0, cur_r.raw_y}) - $signed({1'b0, cfg.y_min}))
                   * $signed({11'b0, Y_TOP});
      end
      ST_DIVP: if (div_done) p_r <= (praw <= cfg.threshold) ? 16'd0 : praw;
      ST_DIVX: if (div_done)
        sx_r <= scale_fin(div_quot[20:0], sxn_r[20] ^ dx_r[10], dx_r == 11'sd0, X_TOP);
      ST_UPD: if (held_r && !deb_n) rel_r <= held_id_r;
      ST_HIT: begin
        if (hit) down_r <= rd_slot.id;
        idx_r <= idx_r + 1'b1;
      end
      ST_ADD: begin
        if (valid_r[MAX_BUTTONS-1]) begin
          drop_r <= 1'b1;
        end else begin
          for (int k = MAX_BUTTONS - 1; k > 0; k--) slot_r[k] <= slot_r[k-1];
          slot_r[0] <= '{cur_r.rect_left, cur_r.rect_top, cur_r.rect_width,
                         cur_r.rect_height, cur_r.button_id};
        end
      end
      ST_REM: begin
        if (valid_r[idx_r] && rd_slot.id != cur_r.button_id) begin
          slot_r[wr_r[SLOT_W-1:0]] <= rd_slot;
          wr_r <= wr_r + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      ST_DONE: begin
        if (fin) begin
          out_r.touched     <= deb_r;
          out_r.touch_x     <= deb_r ? lx_r : 10'd0;
          out_r.touch_y     <= deb_r ? ly_r : 10'd0;
          out_r.pressure    <= p_r;
          out_r.down_id     <= down_r;
          out_r.released_id <= rel_r;
          out_r.add_dropped <= drop_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire
